// ===== hdl/css_pkg.sv =====
`default_nettype none
package css_pkg;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChBs    = 8'h5C;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       last;
  } res_t;

  typedef struct packed {
    logic in_quote;
    logic is_double;
  } quote_t;

  function automatic quote_t quote_step(quote_t q, logic [7:0] c, logic prev_bs);
    quote_t r;
    logic [7:0] closer;
    r = q;
    closer = q.is_double ? ChDq : ChSq;
    if (!q.in_quote && (c == ChDq || c == ChSq)) begin
      r.in_quote  = 1'b1;
      r.is_double = (c == ChDq);
    end else if (q.in_quote && c == closer && !prev_bs) begin
      r.in_quote  = 1'b0;
      r.is_double = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/css_comment_stripper.sv =====
// Lookahead: a kept byte is held back one request before it is queued.
// Throughput: one request per cycle while in_ready is high; a final request
//   pushes up to two results into a four-entry result queue that drains one
//   result per cycle while out_res_ready is high.
// Reset: synchronous, active low; clears lookahead, comment and quote state
//   and empties the result queue.
`default_nettype none
module css_comment_stripper (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_final,
  output logic            out_res_valid,
  input  wire logic       out_res_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_stream_end
);
  import css_pkg::*;

  logic             held_valid_r, held_valid_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             held_bs_r, held_bs_nxt;
  logic             in_comment_r, in_comment_nxt;
  quote_t           quote_r, quote_nxt;

  res_t             q_r [QDepth];
  logic [QAw-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QAw:0]     cnt_r, cnt_nxt;

  logic             acc, pop;
  logic             open0, close0, emit0, consumed, emit1, prev_bs1, comment1;
  quote_t           quote1, quote2;
  res_t             res0, res1;
  logic             push0, push1;
  logic [QAw:0]     npush;

  assign in_ready = (cnt_r <= (QAw+1)'(QDepth - 2));
  assign acc      = in_valid && in_ready;
  assign out_res_valid = (cnt_r != '0);
  assign pop      = out_res_valid && out_res_ready;
  assign out_byte       = q_r[rd_r].data;
  assign out_valid      = q_r[rd_r].kept;
  assign out_stream_end = q_r[rd_r].last;

  always_comb begin
    open0  = held_valid_r && !quote_r.in_quote && !in_comment_r &&
             held_byte_r == ChSlash && in_byte == ChStar;
    close0 = held_valid_r && in_comment_r && held_byte_r == ChStar && in_byte == ChSlash;
    consumed = open0 || close0;
    emit0  = held_valid_r && !consumed && !in_comment_r;
    comment1 = open0 ? 1'b1 : (close0 ? 1'b0 : in_comment_r);
    quote1 = emit0 ? quote_step(quote_r, held_byte_r, held_bs_r) : quote_r;
    prev_bs1 = held_valid_r && held_byte_r == ChBs;
    emit1  = in_is_final && !consumed && !comment1;
    quote2 = quote1;

    res0.data = held_byte_r;
    res0.kept = 1'b1;
    res0.last = in_is_final && !emit1;
    res1.data = emit1 ? in_byte : 8'h00;
    res1.kept = emit1;
    res1.last = 1'b1;

    push0 = acc && emit0;
    push1 = acc && in_is_final && (emit1 || !emit0);
    npush = (QAw+1)'(push0) + (QAw+1)'(push1);

    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    held_bs_nxt    = held_bs_r;
    in_comment_nxt = in_comment_r;
    quote_nxt      = quote_r;
    if (acc) begin
      if (in_is_final) begin
        held_valid_nxt = 1'b0;
        held_byte_nxt  = 8'h00;
        held_bs_nxt    = 1'b0;
        in_comment_nxt = 1'b0;
        quote_nxt      = '0;
      end else begin
        held_valid_nxt = !consumed;
        held_byte_nxt  = consumed ? 8'h00 : in_byte;
        held_bs_nxt    = !consumed && prev_bs1;
        in_comment_nxt = comment1;
        quote_nxt      = quote2;
      end
    end

    wr_nxt  = wr_r + QAw'(npush);
    rd_nxt  = rd_r + QAw'(pop);
    cnt_nxt = cnt_r + npush - (QAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_byte_r  <= 8'h00;
      held_bs_r    <= 1'b0;
      in_comment_r <= 1'b0;
      quote_r      <= '0;
      wr_r         <= '0;
      rd_r         <= '0;
      cnt_r        <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      held_bs_r    <= held_bs_nxt;
      in_comment_r <= in_comment_nxt;
      quote_r      <= quote_nxt;
      wr_r         <= wr_nxt;
      rd_r         <= rd_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // write the held result first, the final result behind it
  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wr_r] <= res0;
    end
    if (push1) begin
      q_r[push0 ? wr_r + QAw'(1) : wr_r] <= res1;
    end
  end

endmodule
`default_nettype wire
